// ===== sv/swrt_pkg.sv =====
`timescale 1ns / 1ps
package swrt_pkg;

  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int CNT_W       = 11;
  localparam int TOTAL_W     = 21;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;
  localparam int FUNC_W      = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 3'd0,
    FN_MARK    = 3'd1,
    FN_QUERY   = 3'd2,
    FN_RESTART = 3'd3,
    FN_NEXT    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_NEXT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic             marked;
    logic [ROW_W-1:0] lo;
    logic [ROW_W-1:0] hi;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic rd_next;
    logic sweep;
    logic step_exec;
    logic step_next;
    logic step_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic next_hop;
    logic sweep_last;
  } dp_sts_t;

endpackage

// ===== sv/swrt_ctrl.sv =====
`timescale 1ns / 1ps
module swrt_ctrl
  import swrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   reply_r, reply_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    state_nxt = state_r;
    reply_nxt = reply_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = reply_r ? S_REPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.in_clear) begin
            state_nxt = S_SWEEP;
            reply_nxt = 1'b1;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sts.next_hop) begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_NEXT;
        end else if (out_free) begin
          cmd.step_exec = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_NEXT: begin
        if (out_free) begin
          cmd.step_next = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          cmd.step_clear = 1'b1;
          reply_nxt      = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || cmd.step_exec || cmd.step_next ||
                    cmd.step_clear;
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== sv/swrt_dp.sv =====
`timescale 1ns / 1ps
module swrt_dp
  import swrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  input  logic [CNT_W-1:0]      column_count,
  input  logic [CNT_W-1:0]      row_count,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  entry_t mem [MAX_COLUMNS];
  entry_t rd_q;
  entry_t wr_data;
  entry_t mark_entry;
  logic   wr_en, rd_en;
  logic [COL_W-1:0] rd_addr, wr_addr;

  func_t              in_func, func_r;
  logic [COL_W-1:0]   in_col, col_r;
  logic [ROW_W-1:0]   in_row, row_r;
  logic [CNT_W-1:0]   ncols, nrows, next_col;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W:0]   total_sum;
  logic [ROW_W-1:0]   gain;
  logic [COL_W-1:0]   iter_col_r, iter_col_nxt, sweep_r;
  logic [ROW_W-1:0]   iter_row_r, iter_row_nxt;
  logic               iter_more_r, iter_more_nxt;
  logic [OUT_DATA_W-1:0] out_r, out_nxt;
  logic               in_range, stale, at_end, load;
  status_t            status;
  logic               inwin, done;
  logic [COL_W-1:0]   ccol;
  logic [ROW_W-1:0]   crow;

  assign in_func  = func_t'(in_tuser);
  assign in_col   = in_tdata[COL_W-1:0];
  assign in_row   = in_tdata[COL_W+ROW_W-1:COL_W];
  assign next_col = {1'b0, iter_col_r} + CNT_W'(1);

  always_comb begin
    if (column_count == '0) begin
      ncols = CNT_W'(1);
    end else if (column_count > CNT_W'(MAX_COLUMNS)) begin
      ncols = CNT_W'(MAX_COLUMNS);
    end else begin
      ncols = column_count;
    end
    if (row_count == '0) begin
      nrows = CNT_W'(1);
    end else if (row_count > CNT_W'(MAX_ROWS)) begin
      nrows = CNT_W'(MAX_ROWS);
    end else begin
      nrows = row_count;
    end
  end

  always_comb begin
    rd_en = cmd.accept || cmd.rd_next;
    if (cmd.rd_next) begin
      rd_addr = next_col[COL_W-1:0];
    end else begin
      case (in_func)
        FN_RESTART: rd_addr = '0;
        FN_NEXT:    rd_addr = iter_col_r;
        default:    rd_addr = in_col;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      col_r  <= in_col;
      row_r  <= in_row;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      total_r     <= '0;
      iter_col_r  <= '0;
      iter_row_r  <= '0;
      iter_more_r <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_r <= sweep_r + COL_W'(1);
      end
      total_r     <= total_nxt;
      iter_col_r  <= iter_col_nxt;
      iter_row_r  <= iter_row_nxt;
      iter_more_r <= iter_more_nxt;
    end
  end

  always_comb begin
    in_range = ({1'b0, col_r} < ncols) && ({1'b0, row_r} < nrows);
    stale    = !iter_more_r || ({1'b0, iter_col_r} >= ncols) || !rd_q.marked;
    at_end   = iter_row_r >= rd_q.hi;

    sts.in_clear   = in_func == FN_CLEAR;
    sts.sweep_last = sweep_r == '1;
    sts.next_hop   = (func_r == FN_NEXT) && !stale && at_end && (next_col < ncols);

    mark_entry.marked = 1'b1;
    mark_entry.lo     = rd_q.lo;
    mark_entry.hi     = rd_q.hi;
    gain              = '0;
    if (!rd_q.marked) begin
      mark_entry.lo = row_r;
      mark_entry.hi = row_r;
      gain          = ROW_W'(1);
    end else if (row_r < rd_q.lo) begin
      mark_entry.lo = row_r;
      gain          = rd_q.lo - row_r;
    end else if (row_r > rd_q.hi) begin
      mark_entry.hi = row_r;
      gain          = row_r - rd_q.hi;
    end
    total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(gain);
  end

  always_comb begin
    status        = STS_OK;
    inwin         = 1'b0;
    ccol          = '0;
    crow          = '0;
    done          = 1'b0;
    total_nxt     = total_r;
    iter_col_nxt  = iter_col_r;
    iter_row_nxt  = iter_row_r;
    iter_more_nxt = iter_more_r;
    wr_en         = cmd.sweep;
    wr_addr       = sweep_r;
    wr_data       = '0;

    if (cmd.step_clear) begin
      total_nxt = '0;
    end

    if (cmd.step_exec) begin
      case (func_r)
        FN_MARK: begin
          if (!in_range) begin
            status = STS_RANGE;
          end else begin
            wr_en   = 1'b1;
            wr_addr = col_r;
            wr_data = mark_entry;
            if (total_sum[TOTAL_W]) begin
              total_nxt = '1;
            end else begin
              total_nxt = total_sum[TOTAL_W-1:0];
            end
          end
        end
        FN_QUERY: begin
          if (!in_range) begin
            status = STS_RANGE;
          end else begin
            inwin = rd_q.marked && (rd_q.lo <= row_r) && (row_r <= rd_q.hi);
          end
        end
        FN_RESTART: begin
          iter_col_nxt = '0;
          if (rd_q.marked) begin
            iter_row_nxt  = rd_q.lo;
            iter_more_nxt = 1'b1;
          end else begin
            iter_row_nxt  = '0;
            iter_more_nxt = 1'b0;
          end
        end
        FN_NEXT: begin
          if (stale) begin
            iter_more_nxt = 1'b0;
            status        = STS_EMPTY;
            done          = 1'b1;
          end else begin
            ccol = iter_col_r;
            crow = iter_row_r;
            if (at_end) begin
              iter_more_nxt = 1'b0;
              done          = 1'b1;
            end else begin
              iter_row_nxt = iter_row_r + ROW_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.step_next) begin
      ccol = iter_col_r;
      crow = iter_row_r;
      if (rd_q.marked) begin
        iter_col_nxt = next_col[COL_W-1:0];
        iter_row_nxt = rd_q.lo;
      end else begin
        iter_more_nxt = 1'b0;
        done          = 1'b1;
      end
    end

    load = cmd.step_exec || cmd.step_next || cmd.step_clear;
    if (load) begin
      out_nxt = {3'b000, total_nxt, done, crow, ccol, inwin, status};
    end else begin
      out_nxt = out_r;
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== sv/search_window_range_table.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tdata: column, row; tuser: func
// out_      master     out_tvalid/out_tready tdata: status .. window_size
// cfg_      APB slave  psel/penable/pready  register 0 column_count, 4 row_count
//
// Mark, query, restart and a next that stays in its column do one read of the
// column range memory, then its update or write back.
// A next that steps to the following column makes a second read.
// Clear and reset sweep the column range memory one entry a cycle, all 1024
// entries; no transaction is accepted on the input meanwhile.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile and stalls in its last cycle until that register is free.
module search_window_range_table
  import swrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // column[9:0], row[19:10], zero pad
  input  logic [FUNC_W-1:0]     in_tuser,   // func[2:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], in_window[2], cell_column[12:3], cell_row[22:13],
  // iteration_done[23], window_size[44:24], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [CNT_W-1:0] column_count_r, column_count_nxt;
  logic [CNT_W-1:0] row_count_r, row_count_nxt;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  dp_sts_t          sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        row_count_nxt = cfg_pwdata[CNT_W-1:0];
      end else begin
        column_count_nxt = cfg_pwdata[CNT_W-1:0];
      end
    end
    if (cfg_paddr[2]) begin
      cfg_prdata = {{(32 - CNT_W){1'b0}}, row_count_r};
    end else begin
      cfg_prdata = {{(32 - CNT_W){1'b0}}, column_count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= CNT_W'(MAX_COLUMNS);
      row_count_r    <= CNT_W'(MAX_ROWS);
    end else begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  swrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  swrt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .column_count (column_count_r),
    .row_count    (row_count_r),
    .out_tdata    (out_tdata)
  );

endmodule

// ===== sv/swrt_checker.sv =====
`timescale 1ns / 1ps
module swrt_checker
  import swrt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_window_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == STS_OK && out_tdata[23:3] == '0)
    else $error("in_window set alongside an error or a cell");

  a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == STS_EMPTY |-> out_tdata[23] && out_tdata[22:3] == '0)
    else $error("empty iterator result without iteration_done");

  a_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == STS_RANGE |-> out_tdata[23:2] == '0)
    else $error("range error carries a cell or flag");

endmodule

bind search_window_range_table swrt_checker u_swrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
